// File: sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the schedule table
// Beat layouts for the command and result channels, the slot record kept in
// memory, function and status codes, sequencer states and divider constants.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Function codes of a command beat.
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    // Status codes of a result beat.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Configuration space.
    localparam int          CFG_ADDR_W  = 3;
    localparam logic        ADDR_HYPER  = 1'b0;
    localparam logic [31:0] HYPER_RESET = 32'd100000;

    // Gap scaling: gap / 91 by reciprocal multiply and one correction step.
    localparam int          TICKS_W      = 26;
    localparam logic [31:0] TICK_DIVISOR = 32'd91;
    localparam logic [31:0] DIV_MAGIC    = 32'd3020636340;
    localparam int          DIV_SHIFT    = 38;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] release_time;
        logic [7:0]  busy_task;
        logic [7:0]  idle_task;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               task_valid;
        logic [7:0]         run_task;
        logic [TICKS_W-1:0] gap_ticks;
        logic [31:0]        compare_value;
    } res_t;

    typedef struct packed {
        logic [31:0] rel_time;
        logic [7:0]  busy_id;
        logic [7:0]  idle_id;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_CMP,
        ST_ADD_PUT,
        ST_TK_RD1,
        ST_TK_RD2,
        ST_TK_START,
        ST_TK_WAIT,
        ST_FN_RD,
        ST_OUT
    } state_t;

endpackage

// File: sv/time_triggered_schedule_table.sv
// ----------------------------------------------------------------------------
// time_triggered_schedule_table: cyclic time-triggered dispatch table
// Keeps up to SLOTS slots sorted by release time in one RAM and serves add,
// tick and finish commands, one command at a time.
//
//   Channel  Signals                         Beat
//   command  cmd_valid, cmd_ready, cmd       cmd_t: func, release_time, tasks
//   result   res_valid, res_ready, res       res_t: status, task, gap, compare
//   config   psel, penable, pwrite, paddr    hyper_period_us at address 0
//
// A tick makes two RAM reads, of the current slot and the next, a gap add,
// and the three-stage divide by 91.
// An add into a non-empty table walks the table from the tail, one entry per
// cycle through the RAM port, moving later slots up until the new one fits.
// An add into an empty table writes slot 0 directly. A finish reads the
// current slot for its idle task; a rejected or unused command goes straight to the result.
// Reset clears count, cursor and done marks, sets the compare register to 1,
// and does not clear slot contents. A stalled result holds in the output
// register while the next command is accepted and worked on; that command
// then waits in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module time_triggered_schedule_table #(
    parameter int SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  tts_pkg::cmd_t                  cmd,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tts_pkg::res_t                  res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tts_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $bits(tts_pkg::slot_t);

    tts_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   cursor_reg, cursor_next;
    logic            first_reg, first_next;
    logic [31:0]     compare_reg, compare_next;
    logic [31:0]     hyper_reg;
    logic [SLOTS-1:0] done_reg, done_next;
    tts_pkg::cmd_t   cmd_reg, cmd_next;
    tts_pkg::res_t   result_reg, result_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   nxt_reg, nxt_next;
    logic            wrap_reg, wrap_next;
    logic [31:0]     rel_cur_reg, rel_cur_next;
    logic [31:0]     gap_reg, gap_next;
    logic            res_valid_reg, res_valid_next;
    tts_pkg::res_t   res_out_reg, res_out_next;

    // RAM and divider connections.
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    tts_pkg::slot_t  ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [SW-1:0]   ram_rdata;
    tts_pkg::slot_t  rd_slot;
    tts_pkg::slot_t  new_slot;
    logic            div_start;
    logic            div_done;
    logic [tts_pkg::TICKS_W-1:0] div_ticks;

    // Insertion bookkeeping.
    logic            ins_en;
    logic [IW-1:0]   ins_pos;

    // Cursor selection for tick and finish.
    logic [IW-1:0]   base_pos;
    logic [IW-1:0]   adv_pos;
    logic [IW-1:0]   cur_pos;
    logic [IW-1:0]   nxt_pos;
    logic            cur_wrap;
    logic            cfg_write;

    assign rd_slot  = tts_pkg::slot_t'(ram_rdata);
    assign new_slot = '{rel_time: cmd_reg.release_time,
                        busy_id:  cmd_reg.busy_task,
                        idle_id:  cmd_reg.idle_task};

    tts_ram #(
        .WIDTH(SW),
        .DEPTH(SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tts_div91 u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .gap  (gap_reg),
        .done (div_done),
        .ticks(div_ticks)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == tts_pkg::ADDR_HYPER);
    assign prdata    = (paddr[2] == tts_pkg::ADDR_HYPER) ? hyper_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyper_reg <= tts_pkg::HYPER_RESET;
        end
        else if (cfg_write)
        begin
            hyper_reg <= pwdata;
        end
    end

    // Current slot, the one a tick moves to, and the slot after it.
    always_comb
    begin
        base_pos = (CW'(cursor_reg) >= count_reg) ? '0 : cursor_reg;
        adv_pos  = (CW'(base_pos) + CW'(1) < count_reg) ? base_pos + IW'(1) : '0;
        cur_pos  = (cmd.func == tts_pkg::FUNC_TICK && !first_reg) ? adv_pos : base_pos;
        nxt_pos  = (CW'(cur_pos) + CW'(1) < count_reg) ? cur_pos + IW'(1) : '0;
        cur_wrap = (CW'(cur_pos) + CW'(1) == count_reg);
    end

    // Sequencer: next state, RAM accesses and state updates.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        first_next     = first_reg;
        compare_next   = compare_reg;
        done_next      = done_reg;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        idx_next       = idx_reg;
        nxt_next       = nxt_reg;
        wrap_next      = wrap_reg;
        rel_cur_next   = rel_cur_reg;
        gap_next       = gap_reg;
        res_valid_next = res_valid_reg;
        res_out_next   = res_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = new_slot;
        ram_raddr      = '0;
        div_start      = 1'b0;
        ins_en         = 1'b0;
        ins_pos        = '0;

        // The output register empties when its beat is taken.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    result_next = '0;
                    case (cmd.func)
                        tts_pkg::FUNC_ADD:
                        begin
                            if (count_reg >= CW'(SLOTS))
                            begin
                                result_next.status = tts_pkg::STATUS_FULL;
                                state_next         = tts_pkg::ST_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = '{rel_time: cmd.release_time,
                                               busy_id:  cmd.busy_task,
                                               idle_id:  cmd.idle_task};
                                count_next = CW'(1);
                                done_next[0] = 1'b0;
                                state_next = tts_pkg::ST_OUT;
                            end
                            else
                            begin
                                idx_next   = IW'(count_reg - CW'(1));
                                ram_raddr  = IW'(count_reg - CW'(1));
                                state_next = tts_pkg::ST_ADD_CMP;
                            end
                        end
                        tts_pkg::FUNC_TICK, tts_pkg::FUNC_FINISH:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = tts_pkg::STATUS_EMPTY;
                                state_next         = tts_pkg::ST_OUT;
                            end
                            else
                            begin
                                cursor_next = cur_pos;
                                ram_raddr   = cur_pos;
                                nxt_next    = nxt_pos;
                                wrap_next   = cur_wrap;
                                result_next.task_valid = 1'b1;
                                if (cmd.func == tts_pkg::FUNC_TICK)
                                begin
                                    first_next         = 1'b0;
                                    done_next[cur_pos] = 1'b0;
                                    state_next         = tts_pkg::ST_TK_RD1;
                                end
                                else
                                begin
                                    done_next[cur_pos] = 1'b1;
                                    state_next         = tts_pkg::ST_FN_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = tts_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            // Walk down from the tail, moving larger slots up by one.
            tts_pkg::ST_ADD_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IW'(1);
                if (cmd_reg.release_time < rd_slot.rel_time)
                begin
                    ram_wdata = rd_slot;
                    if (idx_reg == '0)
                    begin
                        state_next = tts_pkg::ST_ADD_PUT;
                    end
                    else
                    begin
                        ram_raddr = idx_reg - IW'(1);
                        idx_next  = idx_reg - IW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = new_slot;
                    ins_en     = 1'b1;
                    ins_pos    = idx_reg + IW'(1);
                    state_next = tts_pkg::ST_OUT;
                end
            end

            tts_pkg::ST_ADD_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = new_slot;
                ins_en     = 1'b1;
                ins_pos    = '0;
                state_next = tts_pkg::ST_OUT;
            end

            tts_pkg::ST_TK_RD1:
            begin
                rel_cur_next         = rd_slot.rel_time;
                result_next.run_task = rd_slot.busy_id;
                ram_raddr            = nxt_reg;
                state_next           = tts_pkg::ST_TK_RD2;
            end

            tts_pkg::ST_TK_RD2:
            begin
                gap_next   = rd_slot.rel_time - rel_cur_reg + (wrap_reg ? hyper_reg : 32'd0);
                state_next = tts_pkg::ST_TK_START;
            end

            tts_pkg::ST_TK_START:
            begin
                div_start  = 1'b1;
                state_next = tts_pkg::ST_TK_WAIT;
            end

            tts_pkg::ST_TK_WAIT:
            begin
                if (div_done)
                begin
                    result_next.gap_ticks = div_ticks;
                    compare_next          = compare_reg + 32'(div_ticks);
                    state_next            = tts_pkg::ST_OUT;
                end
            end

            tts_pkg::ST_FN_RD:
            begin
                result_next.run_task = rd_slot.idle_id;
                state_next           = tts_pkg::ST_OUT;
            end

            tts_pkg::ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_out_next               = result_reg;
                    res_out_next.compare_value = compare_reg;
                    res_valid_next             = 1'b1;
                    state_next                 = tts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase

        // Insertion: shift done marks up, clear the new one, keep the cursor on its slot.
        if (ins_en)
        begin
            for (int i = SLOTS - 1; i > 0; i--)
            begin
                if (i > int'(ins_pos))
                begin
                    done_next[i] = done_reg[i-1];
                end
            end
            done_next[ins_pos] = 1'b0;
            count_next = count_reg + CW'(1);
            if (!first_reg && ins_pos <= cursor_reg)
            begin
                cursor_next = cursor_reg + IW'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            first_reg     <= 1'b1;
            compare_reg   <= 32'd1;
            done_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            first_reg     <= first_next;
            compare_reg   <= compare_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        result_reg  <= result_next;
        idx_reg     <= idx_next;
        nxt_reg     <= nxt_next;
        wrap_reg    <= wrap_next;
        rel_cur_reg <= rel_cur_next;
        gap_reg     <= gap_next;
        res_out_reg <= res_out_next;
    end

    assign cmd_ready = (state_reg == tts_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_out_reg;

endmodule

// File: sv/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered in the cycle after the
// address is presented.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tts_div91.sv
// ----------------------------------------------------------------------------
// tts_div91: three-stage divider of a 32-bit gap by 91
// Multiplies by a 32-bit reciprocal, fixes the quotient with one compare and
// increment, and clamps the result to at least one tick.
// ----------------------------------------------------------------------------
module tts_div91 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 gap,
    output logic                        done,
    output logic [tts_pkg::TICKS_W-1:0] ticks
);

    logic [31:0]                 gap1_reg;
    logic [63:0]                 prod1_reg;
    logic [tts_pkg::TICKS_W-1:0] q2_reg;
    logic [7:0]                  r2_reg;
    logic [tts_pkg::TICKS_W-1:0] ticks3_reg;
    logic [2:0]                  v_reg;

    logic [tts_pkg::TICKS_W-1:0] q0;
    logic [31:0]                 q0_times_d;
    logic [tts_pkg::TICKS_W-1:0] q_fix;

    // The estimate is the true quotient or one below it.
    assign q0         = prod1_reg[tts_pkg::DIV_SHIFT +: tts_pkg::TICKS_W];
    assign q0_times_d = 32'(q0) * tts_pkg::TICK_DIVISOR;
    assign q_fix      = (32'(r2_reg) >= tts_pkg::TICK_DIVISOR) ?
                        q2_reg + tts_pkg::TICKS_W'(1) : q2_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], start};
        end
    end

    // Data stages: product, remainder, corrected and clamped quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gap1_reg  <= gap;
            prod1_reg <= 64'(gap) * 64'(tts_pkg::DIV_MAGIC);
        end
        q2_reg     <= q0;
        r2_reg     <= 8'(gap1_reg - q0_times_d);
        ticks3_reg <= (q_fix == '0) ? tts_pkg::TICKS_W'(1) : q_fix;
    end

    assign done  = v_reg[2];
    assign ticks = ticks3_reg;

endmodule

// File: sv/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker: port-level checks of the schedule table
// Watches the result channel and the consistency of result beats.
// ----------------------------------------------------------------------------
module tts_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input tts_pkg::res_t res
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // A rejected command dispatches nothing and leaves no gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != tts_pkg::STATUS_OK |->
        !res.task_valid && res.gap_ticks == '0)
        else $error("error status with a dispatched task");

    // Without a dispatch the task id reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.task_valid |-> res.run_task == 8'd0)
        else $error("task id set without dispatch");

    // A nonzero gap comes only with a dispatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.gap_ticks != '0 |-> res.task_valid && res.status == tts_pkg::STATUS_OK)
        else $error("gap reported without a tick dispatch");

endmodule

bind time_triggered_schedule_table tts_checker u_tts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
);
